// ----- rtl/signed_menger_curvature_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the signed Menger curvature unit
// Each macro wraps one concurrent assertion on the unit clock and reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_MENGER_CURVATURE_UNIT_ASSERT_SVH
`define SIGNED_MENGER_CURVATURE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMCU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMCU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/smc_pkg.sv -----
// ----------------------------------------------------------------------------
// smc_pkg
// Types and fixed widths shared by the curvature unit and its serial units.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int COORD_W   = 32;
    localparam int INDEX_W   = 18;
    localparam int CURV_W    = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int MUL_W     = 32;
    localparam int MUL_DIGIT = 4;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SQRT_IN_W = 64;
    localparam int ROOT_W    = 32;
    localparam int DIV_W     = 64;
    localparam int QUO_W     = 33;
    localparam int STEP_W    = 7;
    localparam int EXP_W     = 6;
    localparam int SINE_FRAC = 30;
    localparam int SN_W      = 31;
    localparam int EXP_INIT  = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]       vertex_index;
        logic signed [CURV_W-1:0] curvature;
        logic                     final_res;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
    } pts_t;

    typedef struct packed {
        logic start;
        pts_t pts;
    } core_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [CURV_W-1:0] curvature;
    } core_rsp_t;

    typedef enum logic [1:0] {ST_IDLE, ST_NEXT, ST_WAIT, ST_EMIT} seq_state_t;

    typedef enum logic [2:0] {K_J1, K_J2, K_J3, K_Z1, K_Z0} kind_t;

    typedef enum logic [3:0] {
        C_IDLE, C_DIFF, C_SCALE, C_SQ_A, C_SQ_B, C_ROOT, C_CHECK,
        C_CROSS_A, C_CROSS_B, C_AB, C_SINE, C_CURV, C_DONE
    } core_state_t;

endpackage

// ----- rtl/smc_mul.sv -----
// ----------------------------------------------------------------------------
// smc_mul
// Unsigned digit-serial multiplier, one 4-bit digit of op_b per cycle.
// ----------------------------------------------------------------------------
module smc_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [smc_pkg::MUL_W-1:0]    op_a,
    input  logic [smc_pkg::MUL_W-1:0]    op_b,
    output logic                         done,
    output logic [smc_pkg::PROD_W-1:0]   product
);
    localparam int W     = smc_pkg::MUL_W;
    localparam int DG    = smc_pkg::MUL_DIGIT;
    localparam int SUM_W = W + DG;
    localparam int STEPS = W / DG;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     a_reg, a_next;
    logic [W-1:0]     hi_reg, hi_next;
    logic [W-1:0]     lo_reg, lo_next;
    logic [SUM_W-1:0] sum;

    always_comb begin
        sum       = SUM_W'(hi_reg) + SUM_W'(a_reg) * SUM_W'(lo_reg[DG-1:0]);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = op_a;
            hi_next   = '0;
            lo_next   = op_b;
        end else if (busy_reg) begin
            // The low digit of the running sum is a finished product bit group.
            hi_next  = sum[SUM_W-1:DG];
            lo_next  = {sum[DG-1:0], lo_reg[W-1:DG]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ----- rtl/smc_sqrt.sv -----
// ----------------------------------------------------------------------------
// smc_sqrt
// Restoring integer square root, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module smc_sqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [smc_pkg::SQRT_IN_W-1:0]   radicand,
    output logic                            done,
    output logic [smc_pkg::ROOT_W-1:0]      root
);
    localparam int IN_W  = smc_pkg::SQRT_IN_W;
    localparam int RW    = smc_pkg::ROOT_W;
    localparam int REM_W = RW + 3;
    localparam int CNT_W = $clog2(RW);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(RW - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IN_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [RW-1:0]    root_reg, root_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    always_comb begin
        rem_sh    = {rem_reg[REM_W-3:0], rad_reg[IN_W-1:IN_W-2]};
        trial     = REM_W'({root_reg, 2'b01});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next = {rad_reg[IN_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/smc_div.sv -----
// ----------------------------------------------------------------------------
// smc_div
// Restoring divider, one quotient bit per cycle, with a sticky overflow flag.
// ----------------------------------------------------------------------------
module smc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [smc_pkg::DIV_W-1:0]     rem_init,
    input  logic [smc_pkg::DIV_W-1:0]     dividend,
    input  logic [smc_pkg::DIV_W-1:0]     divisor,
    input  logic [smc_pkg::STEP_W-1:0]    steps,
    output logic                          done,
    output logic [smc_pkg::QUO_W-1:0]     quotient,
    output logic                          overflow
);
    localparam int W  = smc_pkg::DIV_W;
    localparam int QW = smc_pkg::QUO_W;
    localparam int SW = smc_pkg::STEP_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [QW-1:0] q_reg, q_next;
    logic          ovf_reg, ovf_next;
    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          ge;

    always_comb begin
        rem_sh    = {rem_reg, dvd_reg[W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        ge        = (rem_sh >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = rem_init;
            dvd_next  = dividend;
            dvs_next  = divisor;
            q_next    = '0;
            ovf_next  = 1'b0;
        end else if (busy_reg) begin
            rem_next = ge ? diff[W-1:0] : rem_sh[W-1:0];
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            q_next   = {q_reg[QW-2:0], ge};
            ovf_next = ovf_reg | q_reg[QW-1];
            cnt_next = cnt_reg - SW'(1);
            if (cnt_reg == SW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign overflow = ovf_reg;

endmodule

// ----- rtl/smc_core.sv -----
// ----------------------------------------------------------------------------
// smc_core
// Curvature of one point triple, sequenced over the shared serial units.
// ----------------------------------------------------------------------------
module smc_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  smc_pkg::core_req_t    req,
    output smc_pkg::core_rsp_t    rsp
);
    localparam int DW = smc_pkg::DIFF_W;
    localparam int MW = smc_pkg::MUL_W;
    localparam int PW = smc_pkg::PROD_W;
    localparam int RW = smc_pkg::ROOT_W;
    localparam int VW = smc_pkg::DIV_W;
    localparam int QW = smc_pkg::QUO_W;
    localparam int SW = smc_pkg::STEP_W;
    localparam int EW = smc_pkg::EXP_W;
    localparam int CW = smc_pkg::CURV_W;
    localparam int NW = smc_pkg::SN_W;
    localparam logic [NW-1:0] SINE_ONE = NW'(1) << smc_pkg::SINE_FRAC;
    localparam logic [QW-1:0] POS_LIM  = {2'b00, {(CW-1){1'b1}}};
    localparam logic [QW-1:0] NEG_LIM  = {2'b01, {(CW-1){1'b0}}};

    smc_pkg::core_state_t state_reg, state_next;

    logic [DW-1:0]        mag_reg [6];
    logic [DW-1:0]        mag_next [6];
    logic [5:0]           sgn_reg, sgn_next;
    logic [RW-1:0]        side_reg [3];
    logic [RW-1:0]        side_next [3];
    logic [1:0]           j_reg, j_next;
    logic [EW-1:0]        exp_reg, exp_next;
    logic [PW-1:0]        sq_reg, sq_next;
    logic signed [PW-1:0] p1_reg, p1_next;
    logic [PW-1:0]        n_reg, n_next;
    logic                 neg_reg, neg_next;
    logic [CW-1:0]        res_reg, res_next;

    logic signed [DW-1:0] dif [6];
    logic [DW-1:0]        orv;
    logic signed [PW-1:0] p2;
    logic signed [PW-1:0] cr;
    logic [QW-1:0]        kq;
    logic [NW-1:0]        sn_src;

    logic          mul_start, mul_done;
    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;
    logic          sqrt_start, sqrt_done;
    logic [smc_pkg::SQRT_IN_W-1:0] sqrt_in;
    logic [RW-1:0] sqrt_root;
    logic          div_start, div_done, div_ovf;
    logic [VW-1:0] div_rem, div_dvd, div_dvs;
    logic [SW-1:0] div_steps;
    logic [QW-1:0] div_q;

    smc_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_a(mul_a), .op_b(mul_b), .done(mul_done), .product(mul_p)
    );

    smc_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start),
        .radicand(sqrt_in), .done(sqrt_done), .root(sqrt_root)
    );

    smc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .rem_init(div_rem), .dividend(div_dvd), .divisor(div_dvs),
        .steps(div_steps), .done(div_done), .quotient(div_q), .overflow(div_ovf)
    );

    always_comb begin
        dif[0] = signed'({req.pts.cx[MW-1], req.pts.cx}) - signed'({req.pts.px[MW-1], req.pts.px});
        dif[1] = signed'({req.pts.cy[MW-1], req.pts.cy}) - signed'({req.pts.py[MW-1], req.pts.py});
        dif[2] = signed'({req.pts.nx[MW-1], req.pts.nx}) - signed'({req.pts.cx[MW-1], req.pts.cx});
        dif[3] = signed'({req.pts.ny[MW-1], req.pts.ny}) - signed'({req.pts.cy[MW-1], req.pts.cy});
        dif[4] = signed'({req.pts.nx[MW-1], req.pts.nx}) - signed'({req.pts.px[MW-1], req.pts.px});
        dif[5] = signed'({req.pts.ny[MW-1], req.pts.ny}) - signed'({req.pts.py[MW-1], req.pts.py});
        orv = mag_reg[0] | mag_reg[1] | mag_reg[2] | mag_reg[3] | mag_reg[4] | mag_reg[5];
        p2  = (sgn_reg[1] ^ sgn_reg[2]) ? -signed'(mul_p) : signed'(mul_p);
        cr  = p1_reg - p2;
        kq  = div_q;
        sn_src = (state_reg == smc_pkg::C_SINE) ? div_q[NW-1:0] : SINE_ONE;

        state_next = state_reg;
        for (int i = 0; i < 6; i++) begin
            mag_next[i] = mag_reg[i];
        end
        for (int i = 0; i < 3; i++) begin
            side_next[i] = side_reg[i];
        end
        sgn_next = sgn_reg;
        j_next   = j_reg;
        exp_next = exp_reg;
        sq_next  = sq_reg;
        p1_next  = p1_reg;
        n_next   = n_reg;
        neg_next = neg_reg;
        res_next = res_reg;

        mul_start  = 1'b0;
        mul_a      = mag_reg[0][MW-1:0];
        mul_b      = mag_reg[0][MW-1:0];
        sqrt_start = 1'b0;
        sqrt_in    = sq_reg + mul_p;
        div_start  = 1'b0;
        div_rem    = '0;
        div_dvd    = {sn_src, (VW-NW)'(0)};
        div_dvs    = VW'(side_reg[2]);
        div_steps  = SW'(NW) + SW'(exp_reg);

        unique case (state_reg)
            smc_pkg::C_IDLE: begin
                if (req.start) begin
                    for (int i = 0; i < 6; i++) begin
                        sgn_next[i] = dif[i][DW-1];
                        mag_next[i] = dif[i][DW-1] ? DW'(-dif[i]) : DW'(dif[i]);
                    end
                    state_next = smc_pkg::C_DIFF;
                end
            end
            smc_pkg::C_DIFF: begin
                exp_next = EW'(smc_pkg::EXP_INIT);
                res_next = '0;
                // Coincident points leave a zero side and give zero curvature.
                if ((mag_reg[0] == '0 && mag_reg[1] == '0) ||
                    (mag_reg[2] == '0 && mag_reg[3] == '0) ||
                    (mag_reg[4] == '0 && mag_reg[5] == '0)) begin
                    state_next = smc_pkg::C_DONE;
                end else begin
                    state_next = smc_pkg::C_SCALE;
                end
            end
            smc_pkg::C_SCALE: begin
                // One bit of normalization per cycle toward [2^29, 2^30).
                if (orv[DW-1:30] != '0) begin
                    for (int i = 0; i < 6; i++) begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                    exp_next = exp_reg - EW'(1);
                end else if (!orv[29]) begin
                    for (int i = 0; i < 6; i++) begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                    exp_next = exp_reg + EW'(1);
                end else begin
                    mul_start  = 1'b1;
                    j_next     = 2'd0;
                    state_next = smc_pkg::C_SQ_A;
                end
            end
            smc_pkg::C_SQ_A: begin
                if (mul_done) begin
                    sq_next    = mul_p;
                    mul_start  = 1'b1;
                    mul_a      = mag_reg[1][MW-1:0];
                    mul_b      = mag_reg[1][MW-1:0];
                    state_next = smc_pkg::C_SQ_B;
                end
            end
            smc_pkg::C_SQ_B: begin
                if (mul_done) begin
                    sqrt_start = 1'b1;
                    state_next = smc_pkg::C_ROOT;
                end
            end
            smc_pkg::C_ROOT: begin
                if (sqrt_done) begin
                    side_next[0] = side_reg[1];
                    side_next[1] = side_reg[2];
                    side_next[2] = sqrt_root;
                    // Rotate the next side's components into the operand slots.
                    for (int i = 0; i < 6; i++) begin
                        mag_next[i] = mag_reg[(i + 2) % 6];
                        sgn_next[i] = sgn_reg[(i + 2) % 6];
                    end
                    j_next = j_reg + 2'd1;
                    if (j_reg == 2'd2) begin
                        state_next = smc_pkg::C_CHECK;
                    end else begin
                        mul_start  = 1'b1;
                        mul_a      = mag_reg[2][MW-1:0];
                        mul_b      = mag_reg[2][MW-1:0];
                        state_next = smc_pkg::C_SQ_A;
                    end
                end
            end
            smc_pkg::C_CHECK: begin
                if (side_reg[0] == '0 || side_reg[1] == '0 || side_reg[2] == '0) begin
                    state_next = smc_pkg::C_DONE;
                end else begin
                    mul_start  = 1'b1;
                    mul_a      = mag_reg[0][MW-1:0];
                    mul_b      = mag_reg[3][MW-1:0];
                    state_next = smc_pkg::C_CROSS_A;
                end
            end
            smc_pkg::C_CROSS_A: begin
                if (mul_done) begin
                    p1_next    = (sgn_reg[0] ^ sgn_reg[3]) ? -signed'(mul_p) : signed'(mul_p);
                    mul_start  = 1'b1;
                    mul_a      = mag_reg[1][MW-1:0];
                    mul_b      = mag_reg[2][MW-1:0];
                    state_next = smc_pkg::C_CROSS_B;
                end
            end
            smc_pkg::C_CROSS_B: begin
                if (mul_done) begin
                    neg_next = cr[PW-1];
                    n_next   = cr[PW-1] ? PW'(-cr) : PW'(cr);
                    if (cr == '0) begin
                        state_next = smc_pkg::C_DONE;
                    end else begin
                        mul_start  = 1'b1;
                        mul_a      = side_reg[0];
                        mul_b      = side_reg[1];
                        state_next = smc_pkg::C_AB;
                    end
                end
            end
            smc_pkg::C_AB: begin
                if (mul_done) begin
                    if (n_reg >= mul_p) begin
                        // The sine clamps to one; go straight to the final division.
                        div_start  = 1'b1;
                        state_next = smc_pkg::C_CURV;
                    end else begin
                        div_start  = 1'b1;
                        div_rem    = n_reg;
                        div_dvd    = '0;
                        div_dvs    = mul_p;
                        div_steps  = SW'(smc_pkg::SINE_FRAC);
                        state_next = smc_pkg::C_SINE;
                    end
                end
            end
            smc_pkg::C_SINE: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    state_next = smc_pkg::C_CURV;
                end
            end
            smc_pkg::C_CURV: begin
                if (div_done) begin
                    if (neg_reg) begin
                        res_next = (div_ovf || kq > NEG_LIM) ? CW'(-NEG_LIM) : CW'(-kq);
                    end else begin
                        res_next = (div_ovf || kq > POS_LIM) ? CW'(POS_LIM) : CW'(kq);
                    end
                    state_next = smc_pkg::C_DONE;
                end
            end
            smc_pkg::C_DONE: begin
                state_next = smc_pkg::C_IDLE;
            end
            default: begin
                state_next = smc_pkg::C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smc_pkg::C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 6; i++) begin
            mag_reg[i] <= mag_next[i];
        end
        for (int i = 0; i < 3; i++) begin
            side_reg[i] <= side_next[i];
        end
        sgn_reg <= sgn_next;
        j_reg   <= j_next;
        exp_reg <= exp_next;
        sq_reg  <= sq_next;
        p1_reg  <= p1_next;
        n_reg   <= n_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.done      = (state_reg == smc_pkg::C_DONE);
    assign rsp.curvature = signed'(res_reg);

endmodule

// ----- rtl/signed_menger_curvature_unit.sv -----
// ----------------------------------------------------------------------------
// signed_menger_curvature_unit
// Streams the vertices of a closed polyline and returns the signed discrete
// curvature of every vertex, with indices wrapping around the loop.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload             Handshake
//   s_        in         x, y, last          s_valid / s_ready
//   m_        out        vertex_index,       m_valid / m_ready
//                        curvature, final_res
//
// One vertex is taken at a time and yields zero to three results. The run of a
// curvature on the shared core is set by the 2-bit-per-cycle square root (three
// runs), the 1-bit-per-cycle divider (up to two runs) and the normalization
// shift. Coincident points finish before the serial units run, and a collinear
// triple skips both divisions. A closing vertex therefore runs the core up to
// three times.
// Reset is synchronous and active low; it clears the control state only.
// A stalled result sits in the output register while the next result is
// being computed; the sequencer waits for that register only at hand-over.
`include "signed_menger_curvature_unit_assert.svh"

module signed_menger_curvature_unit #(
    parameter int MAX_POINTS = 262144
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  smc_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output smc_pkg::out_item_t   m_data
);
    localparam int CNT_W = $clog2(MAX_POINTS);
    localparam int IW    = (CNT_W > smc_pkg::INDEX_W) ? CNT_W : smc_pkg::INDEX_W;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_POINTS - 1);
    localparam int XW    = smc_pkg::COORD_W;

    smc_pkg::seq_state_t state_reg, state_next;

    // Loop vertices. The newest vertex of the current transfer sits in cur.
    logic signed [XW-1:0] first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [XW-1:0] second_x_reg, second_x_next, second_y_reg, second_y_next;
    logic signed [XW-1:0] older_x_reg, older_x_next, older_y_reg, older_y_next;
    logic signed [XW-1:0] newer_x_reg, newer_x_next, newer_y_reg, newer_y_next;
    logic signed [XW-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    smc_pkg::kind_t       kind_reg [3];
    smc_pkg::kind_t       kind_next [3];
    logic [1:0]           pend_reg, pend_next;
    smc_pkg::out_item_t   res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    smc_pkg::out_item_t   m_data_reg, m_data_next;

    smc_pkg::core_req_t   req;
    smc_pkg::core_rsp_t   rsp;

    logic                 accept;
    logic                 last_eff;
    logic                 out_free;
    logic [IW-1:0]        idx_wide;
    logic [IW-1:0]        idx_prev_wide;

    smc_core u_core (
        .aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp)
    );

    always_comb begin
        accept        = s_valid && (state_reg == smc_pkg::ST_IDLE);
        // The transfer that fills the last slot closes the loop regardless of its flag.
        last_eff      = s_data.last || (cnt_reg == LAST_IDX);
        out_free      = !m_valid_reg || m_ready;
        idx_wide      = IW'(idx_reg);
        idx_prev_wide = IW'(idx_reg - CNT_W'(1));

        state_next    = state_reg;
        first_x_next  = first_x_reg;
        first_y_next  = first_y_reg;
        second_x_next = second_x_reg;
        second_y_next = second_y_reg;
        older_x_next  = older_x_reg;
        older_y_next  = older_y_reg;
        newer_x_next  = newer_x_reg;
        newer_y_next  = newer_y_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        for (int i = 0; i < 3; i++) begin
            kind_next[i] = kind_reg[i];
        end
        pend_next     = pend_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        req.start     = 1'b0;
        req.pts       = '0;

        unique case (kind_reg[0])
            smc_pkg::K_J1: begin
                req.pts = {older_x_reg, older_y_reg, newer_x_reg, newer_y_reg,
                           cur_x_reg, cur_y_reg};
            end
            smc_pkg::K_J2: begin
                req.pts = {newer_x_reg, newer_y_reg, cur_x_reg, cur_y_reg,
                           first_x_reg, first_y_reg};
            end
            smc_pkg::K_J3: begin
                req.pts = {cur_x_reg, cur_y_reg, first_x_reg, first_y_reg,
                           second_x_reg, second_y_reg};
            end
            default: begin
                req.pts = '0;
            end
        endcase

        unique case (state_reg)
            smc_pkg::ST_IDLE: begin
                if (accept) begin
                    cur_x_next = s_data.x;
                    cur_y_next = s_data.y;
                    idx_next   = cnt_reg;
                    cnt_next   = last_eff ? '0 : cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(0)) begin
                        first_x_next = s_data.x;
                        first_y_next = s_data.y;
                    end
                    if (cnt_reg == CNT_W'(1)) begin
                        second_x_next = s_data.x;
                        second_y_next = s_data.y;
                    end
                    // Plan the results this vertex releases, in output order.
                    kind_next[0] = smc_pkg::K_J1;
                    kind_next[1] = smc_pkg::K_J2;
                    kind_next[2] = smc_pkg::K_J3;
                    if (cnt_reg >= CNT_W'(2)) begin
                        pend_next = last_eff ? 2'd3 : 2'd1;
                    end else if (cnt_reg == CNT_W'(1)) begin
                        kind_next[0] = smc_pkg::K_Z1;
                        kind_next[1] = smc_pkg::K_Z0;
                        pend_next    = last_eff ? 2'd2 : 2'd0;
                    end else begin
                        kind_next[0] = smc_pkg::K_Z0;
                        pend_next    = last_eff ? 2'd1 : 2'd0;
                    end
                    state_next = smc_pkg::ST_NEXT;
                end
            end
            smc_pkg::ST_NEXT: begin
                if (pend_reg == 2'd0) begin
                    // All results out: slide the window of recent vertices.
                    older_x_next = newer_x_reg;
                    older_y_next = newer_y_reg;
                    newer_x_next = cur_x_reg;
                    newer_y_next = cur_y_reg;
                    state_next   = smc_pkg::ST_IDLE;
                end else begin
                    unique case (kind_reg[0]) inside
                        smc_pkg::K_J1, smc_pkg::K_J2, smc_pkg::K_J3: begin
                            req.start  = 1'b1;
                            state_next = smc_pkg::ST_WAIT;
                        end
                        smc_pkg::K_Z1: begin
                            res_next.vertex_index = smc_pkg::INDEX_W'(1);
                            res_next.curvature    = '0;
                            res_next.final_res    = 1'b0;
                            state_next            = smc_pkg::ST_EMIT;
                        end
                        default: begin
                            res_next.vertex_index = '0;
                            res_next.curvature    = '0;
                            res_next.final_res    = 1'b1;
                            state_next            = smc_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            smc_pkg::ST_WAIT: begin
                if (rsp.done) begin
                    res_next.curvature = rsp.curvature;
                    unique case (kind_reg[0])
                        smc_pkg::K_J1: begin
                            res_next.vertex_index = idx_prev_wide[smc_pkg::INDEX_W-1:0];
                            res_next.final_res    = 1'b0;
                        end
                        smc_pkg::K_J2: begin
                            res_next.vertex_index = idx_wide[smc_pkg::INDEX_W-1:0];
                            res_next.final_res    = 1'b0;
                        end
                        default: begin
                            res_next.vertex_index = '0;
                            res_next.final_res    = 1'b1;
                        end
                    endcase
                    state_next = smc_pkg::ST_EMIT;
                end
            end
            smc_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    kind_next[0] = kind_reg[1];
                    kind_next[1] = kind_reg[2];
                    pend_next    = pend_reg - 2'd1;
                    state_next   = smc_pkg::ST_NEXT;
                end
            end
            default: begin
                state_next = smc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= smc_pkg::ST_IDLE;
            cnt_reg     <= '0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_x_reg  <= first_x_next;
        first_y_reg  <= first_y_next;
        second_x_reg <= second_x_next;
        second_y_reg <= second_y_next;
        older_x_reg  <= older_x_next;
        older_y_reg  <= older_y_next;
        newer_x_reg  <= newer_x_next;
        newer_y_reg  <= newer_y_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        idx_reg      <= idx_next;
        for (int i = 0; i < 3; i++) begin
            kind_reg[i] <= kind_next[i];
        end
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == smc_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The sequencer only returns to idle once every planned result has gone out.
    `SMCU_ASSERT_IMP(a_idle_no_pending, aclk, aresetn, state_reg == smc_pkg::ST_IDLE, pend_reg == 2'd0, "idle with results pending")
    // The core only finishes a curvature that the sequencer is waiting for.
    `SMCU_ASSERT_IMP(a_done_in_wait, aclk, aresetn, rsp.done, state_reg == smc_pkg::ST_WAIT, "core finished outside wait")
    // The loop-closing result is always the last one planned for its vertex.
    `SMCU_ASSERT_IMP(a_final_is_last, aclk, aresetn, (state_reg == smc_pkg::ST_EMIT) && out_free && res_reg.final_res, pend_reg == 2'd1, "final result is not the last")
    // An accepted vertex always moves the sequencer to planning.
    `SMCU_ASSERT_NXT(a_accept_plans, aclk, aresetn, s_valid && s_ready, state_reg == smc_pkg::ST_NEXT, "accepted vertex not planned")

endmodule
